// File: rtl/dsrq_pkg.sv
// ----------------------------------------------------------------------------
// dsrq_pkg
// Types and codes shared by the deadline-sorted retransmit queue and its cells.
// ----------------------------------------------------------------------------
package dsrq_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned DlW     = TimeW + 1;
  localparam int unsigned CountW  = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP        = 3'd3,
    OP_CHECK      = 3'd4,
    OP_ERASE      = 3'd5,
    OP_NOP6       = 3'd6,
    OP_NOP7       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [SeqW-1:0]    seq_in;
    logic [TimeW-1:0]   send_time;
    logic [TimeW-1:0]   timeout;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               expired;
    logic [SeqW-1:0]    out_seq;
    logic [HandleW-1:0] out_handle;
    logic [TimeW-1:0]   out_send_time;
    logic [TimeW-1:0]   out_timeout;
    logic [CountW-1:0]  count;
  } res_t;

  typedef struct packed {
    logic [SeqW-1:0]    seq;
    logic [TimeW-1:0]   send_time;
    logic [TimeW-1:0]   timeout;
    logic [HandleW-1:0] handle;
    logic [DlW-1:0]     dl;
  } slot_t;

  // beat-time lookup: evaluated in the cells on the accepting edge
  typedef struct packed {
    logic            calc;
    op_e             op;
    logic [SeqW-1:0] seq;
    logic [DlW-1:0]  dl;
  } cell_cmd_t;

  // update applied in the cycle after the lookup
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_upd_t;

endpackage

// File: rtl/dsrq_cell.sv
// ----------------------------------------------------------------------------
// dsrq_cell
// One queue slot: holds an entry, flags itself for the pending operation and
// moves its entry to or from its neighbours along the chain.
// ----------------------------------------------------------------------------
module dsrq_cell import dsrq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  cell_upd_t upd_i,
  input  logic      occ_i,
  input  logic      is_cnt_i,
  input  logic      is_head_i,
  input  slot_t     new_i,
  input  slot_t     left_i,
  input  slot_t     right_i,
  input  logic      prior_i,
  output logic      prior_o,
  output slot_t     slot_o
);

  slot_t slot_q;
  logic  hit_q;
  logic  hit_d;

  always_comb begin
    case (cmd_i.op)
      OP_PUSH_FRONT: hit_d = is_head_i;
      OP_PUSH_BACK:  hit_d = is_cnt_i;
      OP_INSERT:     hit_d = (occ_i && (cmd_i.dl < slot_q.dl)) || is_cnt_i;
      OP_POP:        hit_d = is_head_i;
      OP_ERASE:      hit_d = occ_i && (slot_q.seq == cmd_i.seq);
      default:       hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.calc) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.ins) begin
      if (prior_i) begin
        slot_q <= left_i;
      end else if (hit_q) begin
        slot_q <= new_i;
      end
    end else if (upd_i.rem) begin
      if (prior_i || hit_q) begin
        slot_q <= right_i;
      end
    end
  end

  assign prior_o = prior_i | hit_q;
  assign slot_o  = slot_q;

endmodule

// File: rtl/deadline_sorted_retransmit_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_retransmit_queue
// Each command is taken while busy is low; the result strobe follows in the
// cycle after start is taken, and busy holds further starts off meanwhile.
// First every cell compares its own entry as start is taken; then the
// position ripples down the chain of cells and the entries shift in place.
// Reset empties the queue and clears the sequence counter; slot contents stay
// undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module deadline_sorted_retransmit_queue import dsrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            pend_q;
  op_e             op_q;
  slot_t           new_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [SeqW-1:0] next_seq_q;
  logic [SeqW-1:0] next_seq_d;
  logic [TimeW-1:0] now_q;

  logic      accept;
  logic      full;
  logic      empty;
  logic      found;
  cell_cmd_t cell_cmd;
  cell_upd_t cell_upd;
  slot_t     new_slot;
  slot_t     slots [QUEUE_DEPTH];
  logic      prior [QUEUE_DEPTH+1];
  res_t      res;
  logic [CntW+CountW-1:0] cnt_ext;

  assign accept = start_i && !pend_q;
  assign busy_o = pend_q;
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign found  = prior[QUEUE_DEPTH];

  assign cell_cmd.calc = accept;
  assign cell_cmd.op   = op_e'(cmd_i.operation);
  assign cell_cmd.seq  = cmd_i.seq_in;
  assign cell_cmd.dl   = {1'b0, cmd_i.send_time} + {1'b0, cmd_i.timeout};

  always_comb begin
    new_slot = new_q;
    if (op_q == OP_PUSH_FRONT) begin
      new_slot.seq = next_seq_q;
    end
  end

  always_comb begin
    cnt_ext    = {{CountW{1'b0}}, count_d};
    res        = '0;
    cell_upd   = '0;
    count_d    = count_q;
    next_seq_d = next_seq_q;
    if (pend_q) begin
      case (op_q)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            cell_upd.ins = 1'b1;
            count_d      = count_q + 1'b1;
            if (op_q == OP_PUSH_FRONT) begin
              res.out_seq = next_seq_q;
              next_seq_d  = next_seq_q + 1'b1;
            end
          end
        end
        OP_POP: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            cell_upd.rem      = 1'b1;
            count_d           = count_q - 1'b1;
            res.out_seq       = slots[0].seq;
            res.out_handle    = slots[0].handle;
            res.out_send_time = slots[0].send_time;
            res.out_timeout   = slots[0].timeout;
          end
        end
        OP_CHECK: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.expired = (slots[0].dl <= {1'b0, now_q});
          end
        end
        OP_ERASE: begin
          if (found) begin
            cell_upd.rem = 1'b1;
            count_d      = count_q - 1'b1;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      cnt_ext   = {{CountW{1'b0}}, count_d};
      res.count = cnt_ext[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      count_q    <= '0;
      next_seq_q <= '0;
    end else begin
      pend_q     <= accept;
      count_q    <= count_d;
      next_seq_q <= next_seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q            <= op_e'(cmd_i.operation);
      now_q           <= cmd_i.now;
      new_q.seq       <= cmd_i.seq_in;
      new_q.send_time <= cmd_i.send_time;
      new_q.timeout   <= cmd_i.timeout;
      new_q.handle    <= cmd_i.handle;
      new_q.dl        <= cell_cmd.dl;
    end
  end

  assign prior[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left;
    slot_t right;
    if (i == 0) begin : g_first
      assign left = new_slot;
    end else begin : g_mid
      assign left = slots[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = slots[i];
    end else begin : g_inner
      assign right = slots[i+1];
    end
    dsrq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cell_cmd),
      .upd_i     (cell_upd),
      .occ_i     (CntW'(i) < count_q),
      .is_cnt_i  (CntW'(i) == count_q),
      .is_head_i (i == 0),
      .new_i     (new_slot),
      .left_i    (left),
      .right_i   (right),
      .prior_i   (prior[i]),
      .prior_o   (prior[i+1]),
      .slot_o    (slots[i])
    );
  end

  assign done_o = pend_q;
  assign res_o  = res;

endmodule
